[sv/threshold_accuracy_calibrator_assert.svh]
// Assertion macros shared by the calibrator RTL
`ifndef THRESHOLD_ACCURACY_CALIBRATOR_ASSERT_SVH
`define THRESHOLD_ACCURACY_CALIBRATOR_ASSERT_SVH

// Same-cycle implication, off during reset
`define TAC_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, off during reset
`define TAC_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[sv/tac_pkg.sv]
// Shared constants and codes for the threshold accuracy calibrator
`default_nettype none

package tac_pkg;

  localparam int SCORE_W  = 16;
  localparam int LABEL_W  = 2;
  localparam int COUNT_W  = 13;
  localparam int REL_W    = 17;
  localparam int FRAC_W   = 16;

  localparam logic [REL_W-1:0] HALF_Q16 = 17'd32768;

  localparam logic [LABEL_W-1:0] LABEL_WRONG = 2'd1;
  localparam logic [LABEL_W-1:0] LABEL_RIGHT = 2'd2;

endpackage

`default_nettype wire

[sv/tac_if.sv]
// Sample and result channel interfaces
`default_nettype none

interface tac_sample_if;
  logic                              valid;
  logic                              ready;
  logic [tac_pkg::SCORE_W-1:0]       score;
  logic [tac_pkg::LABEL_W-1:0]       label;
  logic                              last;

  modport source (output valid, output score, output label, output last, input ready);
  modport sink   (input valid, input score, input label, input last, output ready);
endinterface

interface tac_result_if;
  logic                              valid;
  logic                              ready;
  logic [tac_pkg::SCORE_W-1:0]       mean_score;
  logic [tac_pkg::COUNT_W-1:0]       sample_count;
  logic [tac_pkg::REL_W-1:0]         reliability;
  logic [tac_pkg::SCORE_W-1:0]       best_threshold;
  logic                              from_sweep;

  modport source (output valid, output mean_score, output sample_count,
                  output reliability, output best_threshold, output from_sweep,
                  input ready);
  modport sink   (input valid, input mean_score, input sample_count,
                  input reliability, input best_threshold, input from_sweep,
                  output ready);
endinterface

`default_nettype wire

[sv/tac_div.sv]
// Restoring divider, one quotient bit per cycle
`default_nettype none

module tac_div #(
  parameter int DW = 29,
  parameter int VW = 13
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic [VW:0]     shifted;
  logic [VW+1:0]   diff;

  // dividend bits leave at the top of quo while quotient bits enter at the bottom
  assign shifted  = {rem, quo[DW-1]};
  assign diff     = {1'b0, shifted} - {2'b00, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
        quo  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        if (!diff[VW+1]) begin
          rem <= diff[VW-1:0];
          quo <= {quo[DW-2:0], 1'b1};
        end else begin
          rem <= shifted[VW-1:0];
          quo <= {quo[DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/threshold_accuracy_calibrator.sv]
// Per-sample word: one cycle, accepted back to back until the word marked last.
// After a last word the result word is worked out by the shared bit-serial divider (mean,
// then reliability, which is skipped with no known label) and by the one multiplier of
// the sweep. Input reopens the cycle after the result is taken.
// Synchronous reset clears all counters and sums and returns to idle.
`default_nettype none
`include "threshold_accuracy_calibrator_assert.svh"

module threshold_accuracy_calibrator #(
  parameter int MAX_SAMPLES    = 4096,
  parameter int NUM_THRESHOLDS = 19
) (
  input  wire logic     clk,
  input  wire logic     rst,
  tac_sample_if.sink    samples,
  tac_result_if.source  results
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = CW + tac_pkg::FRAC_W;
  localparam int KW = (NUM_THRESHOLDS > 1) ? $clog2(NUM_THRESHOLDS) : 1;
  localparam int LW = tac_pkg::SCORE_W + $clog2(NUM_THRESHOLDS + 2);
  localparam int PW = 2 * CW;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_MEAN_GO   = 3'd1;
  localparam logic [2:0] S_MEAN_WAIT = 3'd2;
  localparam logic [2:0] S_REL_WAIT  = 3'd3;
  localparam logic [2:0] S_SWEEP_A   = 3'd4;
  localparam logic [2:0] S_SWEEP_B   = 3'd5;
  localparam logic [2:0] S_OUT       = 3'd6;

  logic [2:0]    state;

  logic [CW-1:0] below_count [NUM_THRESHOLDS];
  logic [CW-1:0] below_right [NUM_THRESHOLDS];
  logic [SW-1:0] score_sum;
  logic [CW-1:0] accepted;
  logic [CW-1:0] known_total;
  logic [CW-1:0] right_total;

  logic [tac_pkg::SCORE_W-1:0] mean_q;
  logic [tac_pkg::REL_W-1:0]   rel_q;
  logic [KW-1:0]               k;
  logic [KW-1:0]               best_k;
  logic                        found;
  logic [CW-1:0]               best_count;
  logic [CW-1:0]               best_right;
  logic [PW-1:0]               prod_a;

  logic [tac_pkg::SCORE_W-1:0] thr_tab [NUM_THRESHOLDS];
  logic [NUM_THRESHOLDS-1:0]   below_vec;
  logic [LW-1:0]               scaled;

  logic          take;
  logic          is_known;
  logic          is_right;
  logic          has_room;
  logic          k_last;
  logic [CW-1:0] mul_a;
  logic [CW-1:0] mul_b;
  logic [PW-1:0] mul_p;

  logic          div_start;
  logic          div_busy;
  logic          div_done;
  logic [SW-1:0] div_dividend;
  logic [SW-1:0] div_quo;

  // score below threshold k+1 when score*(N+1) < (k+1)*65536
  assign scaled = LW'(samples.score) * LW'(NUM_THRESHOLDS + 1);

  for (genvar g = 0; g < NUM_THRESHOLDS; g++) begin : g_thr
    localparam logic [LW-1:0] RHS = LW'((g + 1) * 65536);
    localparam int THV = ((g + 1) * 131072 + (NUM_THRESHOLDS + 1)) / (2 * (NUM_THRESHOLDS + 1));
    assign below_vec[g] = scaled < RHS;
    assign thr_tab[g]   = tac_pkg::SCORE_W'(THV);
  end

  assign samples.ready = (state == S_IDLE);
  assign take          = samples.valid && samples.ready;
  assign is_right      = (samples.label == tac_pkg::LABEL_RIGHT);
  assign is_known      = (samples.label == tac_pkg::LABEL_WRONG) || is_right;
  assign has_room      = accepted < CW'(MAX_SAMPLES);
  assign k_last        = (k == KW'(NUM_THRESHOLDS - 1));

  // shared multiplier for the cross-product accuracy compare
  always_comb begin
    if (state == S_SWEEP_A) begin
      mul_a = below_right[k];
      mul_b = best_count;
    end else begin
      mul_a = best_right;
      mul_b = below_count[k];
    end
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  assign div_start    = (state == S_MEAN_GO) ||
                        ((state == S_MEAN_WAIT) && div_done && (known_total != '0));
  assign div_dividend = (state == S_MEAN_GO) ? score_sum
                                             : {right_total, tac_pkg::FRAC_W'(0)};

  tac_div #(
    .DW (SW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  ((state == S_MEAN_GO) ? accepted : known_total),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      score_sum   <= '0;
      accepted    <= '0;
      known_total <= '0;
      right_total <= '0;
      found       <= 1'b0;
      for (int i = 0; i < NUM_THRESHOLDS; i++) begin
        below_count[i] <= '0;
        below_right[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            if (has_room) begin
              score_sum <= score_sum + SW'(samples.score);
              accepted  <= accepted + 1'b1;
              if (is_known) begin
                known_total <= known_total + 1'b1;
                if (is_right) right_total <= right_total + 1'b1;
                for (int i = 0; i < NUM_THRESHOLDS; i++) begin
                  if (below_vec[i]) begin
                    below_count[i] <= below_count[i] + 1'b1;
                    if (is_right) below_right[i] <= below_right[i] + 1'b1;
                  end
                end
              end
            end
            if (samples.last) state <= S_MEAN_GO;
          end
        end
        S_MEAN_GO: state <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (div_done) begin
            mean_q <= (accepted == '0) ? '0 : div_quo[tac_pkg::SCORE_W-1:0];
            k      <= '0;
            found  <= 1'b0;
            if (known_total == '0) begin
              rel_q <= tac_pkg::HALF_Q16;
              state <= S_SWEEP_A;
            end else begin
              state <= S_REL_WAIT;
            end
          end
        end
        S_REL_WAIT: begin
          if (div_done) begin
            rel_q <= div_quo[tac_pkg::REL_W-1:0];
            state <= S_SWEEP_A;
          end
        end
        S_SWEEP_A: begin
          if (below_count[k] == '0 || !found) begin
            if (below_count[k] != '0) begin
              found      <= 1'b1;
              best_k     <= k;
              best_count <= below_count[k];
              best_right <= below_right[k];
            end
            if (k_last) state <= S_OUT;
            else k <= k + 1'b1;
          end else begin
            prod_a <= mul_p;
            state  <= S_SWEEP_B;
          end
        end
        S_SWEEP_B: begin
          if (prod_a > mul_p) begin
            best_k     <= k;
            best_count <= below_count[k];
            best_right <= below_right[k];
          end
          if (k_last) begin
            state <= S_OUT;
          end else begin
            k     <= k + 1'b1;
            state <= S_SWEEP_A;
          end
        end
        S_OUT: begin
          if (results.ready) begin
            state       <= S_IDLE;
            score_sum   <= '0;
            accepted    <= '0;
            known_total <= '0;
            right_total <= '0;
            for (int i = 0; i < NUM_THRESHOLDS; i++) begin
              below_count[i] <= '0;
              below_right[i] <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid          = (state == S_OUT);
  assign results.mean_score     = mean_q;
  assign results.sample_count   = tac_pkg::COUNT_W'(accepted);
  assign results.reliability    = rel_q;
  assign results.best_threshold = found ? thr_tab[best_k] : mean_q;
  assign results.from_sweep     = found;

  `TAC_IMP(a_div_free, clk, rst, div_start, !div_busy)
  `TAC_IMP(a_totals, clk, rst, 1'b1, right_total <= known_total && known_total <= accepted)
  `TAC_IMP(a_rel_range, clk, rst, results.valid, results.reliability <= 17'd65536)
  `TAC_NEXT(a_cleared, clk, rst, results.valid && results.ready,
            accepted == '0 && known_total == '0 && score_sum == '0 && !results.valid)

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the threshold accuracy calibrator
module testbench;

  localparam int MAX_SAMPLES    = 4096;
  localparam int NUM_THR        = 19;
  localparam int STEPS          = NUM_THR + 1;
  localparam longint ONE_Q16    = 65536;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int DRAIN_CYCLES   = 150;
  localparam int HOLD_CYCLES    = 400;
  localparam int CYCLE_LIMIT    = 10000000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [tac_pkg::LABEL_W-1:0] LABEL_UNKNOWN = 2'd0;
  localparam logic [tac_pkg::LABEL_W-1:0] LABEL_SPARE   = 2'd3;

  typedef struct {
    logic [tac_pkg::SCORE_W-1:0] mean_score;
    logic [tac_pkg::COUNT_W-1:0] sample_count;
    logic [tac_pkg::REL_W-1:0]   reliability;
    logic [tac_pkg::SCORE_W-1:0] best_threshold;
    logic                        from_sweep;
  } calib_result_t;

  logic clk;
  logic rst;

  tac_sample_if samples_ch ();
  tac_result_if results_ch ();

  threshold_accuracy_calibrator dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch)
  );

  // Expected result words, oldest first
  calib_result_t pending_results[$];

  // Group accumulators of the predictor
  int unsigned       below_cnt [NUM_THR];
  int unsigned       below_ok  [NUM_THR];
  longint unsigned   score_total;
  int unsigned       n_accepted;
  int unsigned       n_known;
  int unsigned       n_right;

  int unsigned errors;
  int unsigned items_sent;
  int unsigned cycle_count;
  bit          src_idle;
  bit          sink_idle;
  bit          sink_hold;
  event        hold_go;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void log_error(input string msg);
    errors++;
    if (errors <= REPORT_LIMIT)
      $display("%0t: %s", $realtime, msg);
  endfunction

  function automatic void clear_group();
    for (int k = 0; k < NUM_THR; k++) begin
      below_cnt[k] = 0;
      below_ok[k]  = 0;
    end
    score_total = 0;
    n_accepted  = 0;
    n_known     = 0;
    n_right     = 0;
  endfunction

  // Fold one accepted sample into the group; on the last one queue the result
  function automatic void calibrate_sample(input logic [tac_pkg::SCORE_W-1:0] score,
                                           input logic [tac_pkg::LABEL_W-1:0] label,
                                           input logic is_last);
    bit              known;
    bit              right;
    bit              found;
    int              best_k;
    longint unsigned lhs;
    longint unsigned rhs;
    calib_result_t   res;

    known = (label == tac_pkg::LABEL_WRONG) || (label == tac_pkg::LABEL_RIGHT);
    right = (label == tac_pkg::LABEL_RIGHT);
    if (n_accepted < MAX_SAMPLES) begin
      score_total += score;
      n_accepted++;
      if (known) begin
        n_known++;
        if (right)
          n_right++;
        for (int k = 0; k < NUM_THR; k++) begin
          if (longint'(score) * STEPS < longint'(k + 1) * ONE_Q16) begin
            below_cnt[k]++;
            if (right)
              below_ok[k]++;
          end
        end
      end
    end
    if (!is_last)
      return;

    res.mean_score   = (n_accepted != 0) ?
                       tac_pkg::SCORE_W'(score_total / n_accepted) : '0;
    res.sample_count = tac_pkg::COUNT_W'(n_accepted);
    if (n_known != 0)
      res.reliability = tac_pkg::REL_W'((longint'(n_right) * ONE_Q16) / n_known);
    else
      res.reliability = tac_pkg::HALF_Q16;

    found  = 1'b0;
    best_k = 0;
    for (int k = 0; k < NUM_THR; k++) begin
      if (below_cnt[k] == 0)
        continue;
      // cross-multiplied accuracy compare, strict so the lowest k keeps a tie
      lhs = longint'(below_ok[k]) * below_cnt[best_k];
      rhs = longint'(below_ok[best_k]) * below_cnt[k];
      if (!found || lhs > rhs) begin
        found  = 1'b1;
        best_k = k;
      end
    end
    if (found)
      res.best_threshold = tac_pkg::SCORE_W'((longint'(best_k + 1) * ONE_Q16 * 2 + STEPS) /
                                             (2 * STEPS));
    else
      res.best_threshold = res.mean_score;
    res.from_sweep = found;

    pending_results.push_back(res);
    clear_group();
  endfunction

  // Result checker
  always @(posedge clk) begin : result_check
    calib_result_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (pending_results.size() == 0) begin
        log_error($sformatf("unexpected result word: mean %0d count %0d rel %0d thr %0d sweep %0d",
                            results_ch.mean_score, results_ch.sample_count,
                            results_ch.reliability, results_ch.best_threshold,
                            results_ch.from_sweep));
      end else begin
        want = pending_results.pop_front();
        if (results_ch.mean_score !== want.mean_score ||
            results_ch.sample_count !== want.sample_count ||
            results_ch.reliability !== want.reliability ||
            results_ch.best_threshold !== want.best_threshold ||
            results_ch.from_sweep !== want.from_sweep) begin
          log_error($sformatf({"result mismatch: expected mean %0d count %0d rel %0d thr %0d ",
                               "sweep %0d, got mean %0d count %0d rel %0d thr %0d sweep %0d"},
                              want.mean_score, want.sample_count, want.reliability,
                              want.best_threshold, want.from_sweep,
                              results_ch.mean_score, results_ch.sample_count,
                              results_ch.reliability, results_ch.best_threshold,
                              results_ch.from_sweep));
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 150);
  endfunction

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile
  initial begin : receiver_hold
    sink_hold = 1'b0;
    forever begin
      @(hold_go);
      sink_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      sink_hold = 1'b0;
    end
  end

  // Receiver ready
  always @(negedge clk) begin : receiver_ready
    int stall_left;
    if (sink_hold) begin
      results_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      results_ch.ready <= 1'b0;
      stall_left--;
    end else if (sink_idle && $urandom_range(0, 99) < 15) begin
      results_ch.ready <= 1'b0;
      stall_left = pick_stall() - 1;
    end else begin
      results_ch.ready <= 1'b1;
    end
  end

  // Offer one sample word and wait for it to be taken
  task automatic send_sample(input logic [tac_pkg::SCORE_W-1:0] score,
                             input logic [tac_pkg::LABEL_W-1:0] label,
                             input logic is_last);
    int gap;
    gap = src_idle ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      samples_ch.valid <= 1'b0;
    end
    @(negedge clk);
    samples_ch.valid <= 1'b1;
    samples_ch.score <= score;
    samples_ch.label <= label;
    samples_ch.last  <= is_last;
    @(posedge clk);
    while (!samples_ch.ready)
      @(posedge clk);
    calibrate_sample(score, label, is_last);
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    samples_ch.valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [tac_pkg::SCORE_W-1:0] pick_score(input int mode);
    int k;
    int edge_pt;
    case (mode)
      0: return $urandom_range(0, 65535);
      1: begin
        // straddle a threshold boundary
        k       = $urandom_range(1, NUM_THR);
        edge_pt = (k * 65536 + STEPS - 1) / STEPS;
        return tac_pkg::SCORE_W'(edge_pt + $urandom_range(0, 4) - 2);
      end
      2: begin
        case ($urandom_range(0, 3))
          0:       return 16'd0;
          1:       return 16'd1;
          2:       return 16'd65534;
          default: return 16'd65535;
        endcase
      end
      default: return $urandom_range(0, 16383);
    endcase
  endfunction

  function automatic logic [tac_pkg::LABEL_W-1:0] pick_label(input int p_right,
                                                              input int p_unknown);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)
      return LABEL_SPARE;
    if (r < 2 + p_unknown)
      return LABEL_UNKNOWN;
    return ($urandom_range(0, 99) < p_right) ? tac_pkg::LABEL_RIGHT : tac_pkg::LABEL_WRONG;
  endfunction

  task automatic test_corner_groups();
    // one sample at zero: every threshold ties at full accuracy, lowest wins
    send_sample(16'd0, tac_pkg::LABEL_RIGHT, 1'b1);
    // above every threshold: falls back to the mean
    send_sample(16'hFFFF, tac_pkg::LABEL_WRONG, 1'b1);
    // nothing known: reliability one half
    send_sample(16'hFFFF, LABEL_UNKNOWN, 1'b1);
    send_sample(16'h8000, LABEL_SPARE, 1'b1);
    // exactly on the quarter threshold
    send_sample(16'd16383, tac_pkg::LABEL_RIGHT, 1'b0);
    send_sample(16'd16384, tac_pkg::LABEL_WRONG, 1'b0);
    send_sample(16'd16385, tac_pkg::LABEL_WRONG, 1'b1);
    // only the top threshold is strictly better
    send_sample(16'd0, tac_pkg::LABEL_WRONG, 1'b0);
    send_sample(16'd60000, tac_pkg::LABEL_RIGHT, 1'b0);
    send_sample(16'd62258, tac_pkg::LABEL_RIGHT, 1'b1);
    // all right: reliability one
    send_sample(16'd1000, tac_pkg::LABEL_RIGHT, 1'b0);
    send_sample(16'd30000, tac_pkg::LABEL_RIGHT, 1'b0);
    send_sample(16'd65535, tac_pkg::LABEL_RIGHT, 1'b1);
    // lowest boundary, alternating bit patterns
    send_sample(16'h5555, LABEL_SPARE, 1'b0);
    send_sample(16'hAAAA, tac_pkg::LABEL_WRONG, 1'b0);
    send_sample(16'd3276, tac_pkg::LABEL_RIGHT, 1'b0);
    send_sample(16'd3277, tac_pkg::LABEL_WRONG, 1'b1);
    settle();
  endtask

  task automatic test_full_group();
    // words past the group limit are dropped, the last mark still closes it
    for (int i = 0; i < MAX_SAMPLES + 8; i++)
      send_sample(pick_score(0), tac_pkg::LABEL_W'($urandom_range(0, 3)),
                  i == MAX_SAMPLES + 7);
    // next group must start from clean counters
    send_sample(pick_score(0), tac_pkg::LABEL_RIGHT, 1'b1);
    settle();
  endtask

  task automatic test_random_groups();
    int unsigned stop_at;
    int unsigned phase_end;
    int          group_len;
    int          mode;
    int          p_right;
    int          p_unknown;
    int          r;

    stop_at   = items_sent + RANDOM_ITEMS;
    phase_end = 0;
    while (items_sent < stop_at) begin
      if (items_sent >= phase_end) begin
        src_idle  = $urandom_range(0, 3) != 0;
        sink_idle = $urandom_range(0, 3) != 0;
        phase_end = items_sent + 150;
      end
      r = $urandom_range(0, 99);
      if (r < 85)
        group_len = $urandom_range(1, 20);
      else if (r < 97)
        group_len = $urandom_range(21, 120);
      else
        group_len = $urandom_range(121, 400);
      mode      = $urandom_range(0, 3);
      p_right   = $urandom_range(0, 100);
      p_unknown = $urandom_range(0, 50);
      for (int i = 0; i < group_len; i++)
        send_sample(pick_score(mode), pick_label(p_right, p_unknown), i == group_len - 1);
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    settle();
  endtask

  task automatic test_backpressure();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    -> hold_go;
    // short groups back to back, so a result sits unread and the input stalls
    for (int g = 0; g < 4; g++)
      for (int i = 0; i < 3; i++)
        send_sample(pick_score(g), tac_pkg::LABEL_W'($urandom_range(0, 3)), i == 2);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    settle();
  endtask

  initial begin : main_seq
    samples_ch.valid = 1'b0;
    samples_ch.score = '0;
    samples_ch.label = LABEL_UNKNOWN;
    samples_ch.last  = 1'b0;
    results_ch.ready = 1'b0;
    rst              = 1'b1;
    errors           = 0;
    items_sent       = 0;
    cycle_count      = 0;
    src_idle         = 1'b1;
    sink_idle        = 1'b1;
    clear_group();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corner_groups();
    test_full_group();
    test_random_groups();
    test_backpressure();

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
